### src/lvb_pkg.sv
// Shared types, constants and the level classifier for the level warning LED blinker.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package lvb_pkg;

  // Default blink periods in ticks
  localparam int unsigned SLOW_PERIOD_DEF = 200;
  localparam int unsigned FAST_PERIOD_DEF = 100;

  // Field widths
  localparam int LEVEL_W = 8;
  localparam int TICK_W  = 32;

  // Width of a byte-folded tick: 255 * (1 + 3 * (P - 1)) stays below 2^26 for P <= 65535
  localparam int FOLD_W = 26;

  // Threshold reset values
  localparam logic [LEVEL_W-1:0] HIGH_THRESHOLD_RST = 8'd50;
  localparam logic [LEVEL_W-1:0] LOW_THRESHOLD_RST  = 8'd10;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HIGH_THRESHOLD = 1'b0,
    CFG_LOW_THRESHOLD  = 1'b1
  } cfg_idx_t;

  // Level regions
  typedef enum logic [1:0] {
    REGION_LOW  = 2'd0,
    REGION_MED  = 2'd1,
    REGION_HIGH = 2'd2
  } region_t;

  // Per-channel control for one state update
  typedef struct packed {
    logic    both_high;
    region_t region;
  } chan_step_t;

  // High test takes precedence over the low test
  function automatic region_t classify(input logic [LEVEL_W-1:0] level,
                                       input logic [LEVEL_W-1:0] hi,
                                       input logic [LEVEL_W-1:0] lo);
    region_t r;
    if (level > hi) begin
      r = REGION_HIGH;
    end else if (level <= lo) begin
      r = REGION_LOW;
    end else begin
      r = REGION_MED;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### src/lvb_mod.sv
// Four-stage pipeline that reduces a 32-bit tick modulo a constant period.
// Depends on lvb_pkg; stage loads are driven by the top level's pipeline control.
`default_nettype none

module lvb_mod #(
  parameter int unsigned PERIOD = lvb_pkg::SLOW_PERIOD_DEF,
  localparam int RW = $clog2(PERIOD + 1)
) (
  input  wire logic                      clk,
  input  wire logic [3:0]                load,
  input  wire logic [lvb_pkg::TICK_W-1:0] tick,
  output logic      [RW-1:0]             residue
);
  import lvb_pkg::*;

  localparam int PROD_W = 2 * FOLD_W + 1;
  localparam logic [63:0] P64 = 64'(PERIOD);
  // Byte weights 2^(8k) mod PERIOD
  localparam logic [FOLD_W-1:0] C8  = FOLD_W'((64'd1 << 8) % P64);
  localparam logic [FOLD_W-1:0] C16 = FOLD_W'((64'd1 << 16) % P64);
  localparam logic [FOLD_W-1:0] C24 = FOLD_W'((64'd1 << 24) % P64);
  // Reciprocal floor(2^FOLD_W / PERIOD); quotient estimate is low by at most one
  localparam logic [FOLD_W:0] RECIP = (FOLD_W + 1)'((64'd1 << FOLD_W) / P64);
  localparam logic [FOLD_W-1:0] P_F = FOLD_W'(PERIOD);
  localparam logic [RW:0]       P_D = (RW + 1)'(PERIOD);

  logic [FOLD_W-1:0] x0, x1, x2;
  logic [FOLD_W-1:0] q1;
  logic [FOLD_W-1:0] qp2;
  logic [RW-1:0]     r3;

  logic [FOLD_W-1:0] fold;
  logic [PROD_W-1:0] prod;
  logic [RW:0]       diff;
  logic [RW:0]       diff_red;

  // Fold the tick bytes with their weights
  assign fold = FOLD_W'(tick[7:0])
              + FOLD_W'(tick[15:8])  * C8
              + FOLD_W'(tick[23:16]) * C16
              + FOLD_W'(tick[31:24]) * C24;

  // Quotient estimate by reciprocal multiply
  assign prod = PROD_W'(x0) * PROD_W'(RECIP);

  // Remainder lies below twice the period: one conditional subtract
  assign diff     = (RW + 1)'(x2 - qp2);
  assign diff_red = (diff >= P_D) ? (diff - P_D) : diff;

  always_ff @(posedge clk) begin
    if (load[0]) begin
      x0 <= fold;
    end
    if (load[1]) begin
      x1 <= x0;
      q1 <= prod[2*FOLD_W-1:FOLD_W];
    end
    if (load[2]) begin
      x2  <= x1;
      qp2 <= q1 * P_F;
    end
    if (load[3]) begin
      r3 <= diff_red[RW-1:0];
    end
  end

  assign residue = r3;

endmodule

`default_nettype wire

### src/lvb_chan.sv
// Blink state of one warning channel: reference tick and residues, region tracking, toggle.
// Depends on lvb_pkg; tick residues come from two lvb_mod pipelines in the top level.
`default_nettype none

module lvb_chan #(
  parameter int unsigned SLOW_PERIOD = lvb_pkg::SLOW_PERIOD_DEF,
  parameter int unsigned FAST_PERIOD = lvb_pkg::FAST_PERIOD_DEF,
  localparam int RWS = $clog2(SLOW_PERIOD + 1),
  localparam int RWF = $clog2(FAST_PERIOD + 1)
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       upd,
  input  wire lvb_pkg::chan_step_t        step,
  input  wire logic [lvb_pkg::TICK_W-1:0] tick,
  input  wire logic [RWS-1:0]             ts,
  input  wire logic [RWF-1:0]             tf,
  output logic                            led_next
);
  import lvb_pkg::*;

  // 2^32 mod period: correction when the tick distance wraps
  localparam logic [RWS:0] WRAP_S = (RWS + 1)'((64'd1 << TICK_W) % 64'(SLOW_PERIOD));
  localparam logic [RWF:0] WRAP_F = (RWF + 1)'((64'd1 << TICK_W) % 64'(FAST_PERIOD));
  localparam logic [RWS:0] PS_D   = (RWS + 1)'(SLOW_PERIOD);
  localparam logic [RWF:0] PF_D   = (RWF + 1)'(FAST_PERIOD);

  logic [TICK_W-1:0] ref_tick, ref_tick_next;
  logic [RWS-1:0]    ref_rs, ref_rs_next;
  logic [RWF-1:0]    ref_rf, ref_rf_next;
  logic              expect_medium, expect_medium_next;
  logic              toggle, toggle_next;
  logic              led;

  logic          borrow;
  logic [RWS:0]  vs, vs_red;
  logic [RWF:0]  vf, vf_red;
  logic          hit_s, hit_f;
  logic          flip;

  // Distance is a multiple of the period when residues match after wrap correction
  assign borrow = tick < ref_tick;
  assign vs     = (RWS + 1)'(ts) + (borrow ? WRAP_S : '0);
  assign vs_red = (vs >= PS_D) ? (vs - PS_D) : vs;
  assign hit_s  = vs_red[RWS-1:0] == ref_rs;
  assign vf     = (RWF + 1)'(tf) + (borrow ? WRAP_F : '0);
  assign vf_red = (vf >= PF_D) ? (vf - PF_D) : vf;
  assign hit_f  = vf_red[RWF-1:0] == ref_rf;

  // Next state of the channel
  always_comb begin
    ref_tick_next      = ref_tick;
    ref_rs_next        = ref_rs;
    ref_rf_next        = ref_rf;
    expect_medium_next = expect_medium;
    toggle_next        = toggle;
    led_next           = led;
    flip               = 1'b0;
    priority if (step.both_high) begin
      led_next = 1'b0;
    end else begin
      unique case (step.region)
        REGION_HIGH: begin
          toggle_next = 1'b0;
          led_next    = 1'b0;
        end
        REGION_MED: begin
          // entry into medium flips at once
          flip               = expect_medium || hit_s;
          expect_medium_next = 1'b0;
        end
        REGION_LOW: begin
          flip               = !expect_medium || hit_f;
          expect_medium_next = 1'b1;
        end
        default: begin
          led_next = led;
        end
      endcase
      if (flip) begin
        toggle_next   = !toggle;
        led_next      = !toggle;
        ref_tick_next = tick;
        ref_rs_next   = ts;
        ref_rf_next   = tf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_tick      <= '0;
      ref_rs        <= '0;
      ref_rf        <= '0;
      expect_medium <= 1'b1;
      toggle        <= 1'b0;
      led           <= 1'b0;
    end else if (upd) begin
      ref_tick      <= ref_tick_next;
      ref_rs        <= ref_rs_next;
      ref_rf        <= ref_rf_next;
      expect_medium <= expect_medium_next;
      toggle        <= toggle_next;
      led           <= led_next;
    end
  end

endmodule

`default_nettype wire

### src/level_warning_led_blinker_top.sv
// Level warning LED blinker, top level: stream channels, config registers, pipeline control.
// Depends on lvb_pkg, lvb_mod (tick residues) and lvb_chan (per-channel blink state).
//
// Use:
//   s_axis carries one request per update: battery level, fuel level and tick count.
//   m_axis returns one result per request, in order: LED drives and low flags.
//   cfg writes high_threshold (index 0) or low_threshold (index 1); cfg_ready is
//   always high. Write only while no request is in flight.
// Path to m_axis_tvalid: after input accept, the residue pipeline stages
//   (byte fold, reciprocal multiply, quotient times period, final subtract) reduce
//   the tick modulo both periods; then the state update compares stored reference
//   residues and writes the result register.
// Throughput: one request per cycle while m_axis_tready does not hold results back.
// Reset: thresholds return to 50 and 10, both channels go to reference tick 0,
//   toggle off, expecting a medium entry; the pipeline empties.
// Stall: while m_axis_tready is low, results back up one stage at a time; each
//   empty stage still takes a request, and s_axis_tready drops only when all
//   five stages hold an item.
`default_nettype none

module level_warning_led_blinker_top #(
  parameter int unsigned SLOW_PERIOD = lvb_pkg::SLOW_PERIOD_DEF,
  parameter int unsigned FAST_PERIOD = lvb_pkg::FAST_PERIOD_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // input stream
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata, low bit up: battery_level[7:0], fuel_level[15:8], tick[47:16]
  input  wire logic [47:0]                   s_axis_tdata,
  // result stream
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // tdata, low bit up: led_fuel, led_battery, led_ok, battery_low, fuel_low, zeros
  output logic      [7:0]                    m_axis_tdata,
  // configuration writes
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [lvb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [lvb_pkg::LEVEL_W-1:0]   cfg_data
);
  import lvb_pkg::*;

  localparam int RWS    = $clog2(SLOW_PERIOD + 1);
  localparam int RWF    = $clog2(FAST_PERIOD + 1);
  localparam int STAGES = 4;

  // Configuration registers
  logic [LEVEL_W-1:0] high_threshold;
  logic [LEVEL_W-1:0] low_threshold;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      high_threshold <= HIGH_THRESHOLD_RST;
      low_threshold  <= LOW_THRESHOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_HIGH_THRESHOLD: high_threshold <= cfg_data;
        CFG_LOW_THRESHOLD:  low_threshold  <= cfg_data;
      endcase
    end
  end

  // Pipeline control: each stage loads when empty or when its item moves on
  logic [STAGES-1:0] stage_valid;
  logic [STAGES-1:0] take;
  logic [STAGES-1:0] adv;
  logic [STAGES-1:0] load;
  logic              out_valid;
  logic              out_load;

  assign out_load = stage_valid[STAGES-1] && (!out_valid || m_axis_tready);

  always_comb begin
    for (int k = 0; k < STAGES; k++) begin
      take[k] = 1'b0;
      adv[k]  = 1'b0;
    end
    adv[STAGES-1]  = out_load;
    take[STAGES-1] = !stage_valid[STAGES-1] || out_load;
    for (int k = STAGES - 2; k >= 0; k--) begin
      adv[k]  = stage_valid[k] && take[k+1];
      take[k] = !stage_valid[k] || adv[k];
    end
  end

  assign s_axis_tready = take[0];
  assign load[0]       = s_axis_tvalid && s_axis_tready;
  assign load[STAGES-1:1] = adv[STAGES-2:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
      out_valid   <= 1'b0;
    end else begin
      for (int k = 0; k < STAGES; k++) begin
        if (load[k]) begin
          stage_valid[k] <= 1'b1;
        end else if (adv[k]) begin
          stage_valid[k] <= 1'b0;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload travelling alongside the residue pipeline
  logic [LEVEL_W-1:0] batt_stage [STAGES];
  logic [LEVEL_W-1:0] fuel_stage [STAGES];
  logic [TICK_W-1:0]  tick_stage [STAGES];

  always_ff @(posedge clk) begin
    if (load[0]) begin
      batt_stage[0] <= s_axis_tdata[7:0];
      fuel_stage[0] <= s_axis_tdata[15:8];
      tick_stage[0] <= s_axis_tdata[47:16];
    end
    for (int k = 1; k < STAGES; k++) begin
      if (load[k]) begin
        batt_stage[k] <= batt_stage[k-1];
        fuel_stage[k] <= fuel_stage[k-1];
        tick_stage[k] <= tick_stage[k-1];
      end
    end
  end

  // Tick residues for both periods
  logic [RWS-1:0] tick_rs;
  logic [RWF-1:0] tick_rf;

  lvb_mod #(.PERIOD(SLOW_PERIOD)) u_mod_slow (
    .clk     (clk),
    .load    (load),
    .tick    (s_axis_tdata[47:16]),
    .residue (tick_rs)
  );

  lvb_mod #(.PERIOD(FAST_PERIOD)) u_mod_fast (
    .clk     (clk),
    .load    (load),
    .tick    (s_axis_tdata[47:16]),
    .residue (tick_rf)
  );

  // Classify and update both channels as the item enters the result register
  region_t    batt_region;
  region_t    fuel_region;
  logic       both_high;
  chan_step_t batt_step;
  chan_step_t fuel_step;
  logic       led_battery_next;
  logic       led_fuel_next;

  assign batt_region = classify(batt_stage[STAGES-1], high_threshold, low_threshold);
  assign fuel_region = classify(fuel_stage[STAGES-1], high_threshold, low_threshold);
  assign both_high   = (batt_region == REGION_HIGH) && (fuel_region == REGION_HIGH);
  assign batt_step   = '{both_high: both_high, region: batt_region};
  assign fuel_step   = '{both_high: both_high, region: fuel_region};

  lvb_chan #(.SLOW_PERIOD(SLOW_PERIOD), .FAST_PERIOD(FAST_PERIOD)) u_chan_batt (
    .clk      (clk),
    .rst      (rst),
    .upd      (out_load),
    .step     (batt_step),
    .tick     (tick_stage[STAGES-1]),
    .ts       (tick_rs),
    .tf       (tick_rf),
    .led_next (led_battery_next)
  );

  lvb_chan #(.SLOW_PERIOD(SLOW_PERIOD), .FAST_PERIOD(FAST_PERIOD)) u_chan_fuel (
    .clk      (clk),
    .rst      (rst),
    .upd      (out_load),
    .step     (fuel_step),
    .tick     (tick_stage[STAGES-1]),
    .ts       (tick_rs),
    .tf       (tick_rf),
    .led_next (led_fuel_next)
  );

  // Result register
  logic [7:0] out_data;

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= {3'b000,
                   fuel_region == REGION_LOW,
                   batt_region == REGION_LOW,
                   both_high,
                   led_battery_next,
                   led_fuel_next};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

`ifndef NO_ASSERTIONS
  // Result register is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // OK LED excludes warning LEDs and low flags
  a_ok_exclusive: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[2]) |-> (m_axis_tdata[1:0] == 2'b00 &&
                                            m_axis_tdata[4:3] == 2'b00))
    else $error("OK LED with a warning active");

  // A blocked last stage keeps its item
  a_last_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (stage_valid[STAGES-1] && !out_load) |=>
      (stage_valid[STAGES-1] && $stable(tick_stage[STAGES-1])))
    else $error("last pipeline stage overwritten");

  // Input is refused only when every stage is occupied
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (stage_valid == '1 && out_valid))
    else $error("input stalled with room in the pipeline");
`endif

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
// Self-checking testbench for level_warning_led_blinker_top: drives level/tick requests,
// predicts LED drives and low flags in a local blink model, checks results in order.
// Depends on lvb_pkg (types, register indexes, default periods) and the block's RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lvb_pkg::*;

  localparam int unsigned SLOW_TICKS  = SLOW_PERIOD_DEF;
  localparam int unsigned FAST_TICKS  = FAST_PERIOD_DEF;
  localparam int          PIPE_CYCLES = 5;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          MAX_REPORTS = 10;

  // One result as it sits in m_axis_tdata[4:0], led_fuel in bit 0
  typedef struct packed {
    logic fuel_low;
    logic battery_low;
    logic led_ok;
    logic led_battery;
    logic led_fuel;
  } lamp_word_t;

  // Blink state of one channel
  typedef struct {
    logic [31:0] ref_tick;
    logic        expect_med;
    logic        toggle;
    logic        led;
  } blink_chan_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_idx_t    cfg_index = CFG_HIGH_THRESHOLD;
  logic [7:0]  cfg_data = '0;

  // Local copy of the thresholds and channel state
  logic [7:0]  thr_high;
  logic [7:0]  thr_low;
  blink_chan_t batt_chan;
  blink_chan_t fuel_chan;

  lamp_word_t  lamps_due[$];
  int          fault_count = 0;
  int          cycle_count = 0;
  int          hold_left = 0;
  logic        send_idle_on = 1'b1;
  logic        recv_idle_on = 1'b1;

  level_warning_led_blinker_top uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               lamps_due.size());
      $display("FAIL level_warning_led_blinker_top");
      $finish;
    end
  end

  // Long receiver hold-off, counted down here
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Blink model
  // ---------------------------------------------------------------------------

  function automatic region_t level_region(logic [7:0] level);
    region_t r;
    if (level > thr_high) begin
      r = REGION_HIGH;
    end else if (level <= thr_low) begin
      r = REGION_LOW;
    end else begin
      r = REGION_MED;
    end
    return r;
  endfunction

  function automatic blink_chan_t step_channel(blink_chan_t c, region_t r, logic [31:0] tick);
    int unsigned period;
    logic [31:0] tick_gap;
    if (r == REGION_HIGH) begin
      c.toggle = 1'b0;
      c.led    = 1'b0;
      return c;
    end
    // entering medium or low moves the reference to now
    if (r == REGION_MED) begin
      if (c.expect_med) begin
        c.ref_tick   = tick;
        c.expect_med = 1'b0;
      end
      period = SLOW_TICKS;
    end else begin
      if (!c.expect_med) begin
        c.ref_tick   = tick;
        c.expect_med = 1'b1;
      end
      period = FAST_TICKS;
    end
    tick_gap = tick - c.ref_tick;
    if (tick_gap % period == 0) begin
      c.toggle   = ~c.toggle;
      c.led      = c.toggle;
      c.ref_tick = tick;
    end
    return c;
  endfunction

  function automatic lamp_word_t update_lamps(logic [7:0] batt, logic [7:0] fuel,
                                              logic [31:0] tick);
    region_t    rb;
    region_t    rf;
    lamp_word_t w;
    rb = level_region(batt);
    rf = level_region(fuel);
    if (rb == REGION_HIGH && rf == REGION_HIGH) begin
      // toggles and references are kept, only the LEDs go dark
      batt_chan.led = 1'b0;
      fuel_chan.led = 1'b0;
      w.led_ok = 1'b1;
    end else begin
      batt_chan = step_channel(batt_chan, rb, tick);
      fuel_chan = step_channel(fuel_chan, rf, tick);
      w.led_ok = 1'b0;
    end
    w.led_fuel    = fuel_chan.led;
    w.led_battery = batt_chan.led;
    w.battery_low = (rb == REGION_LOW);
    w.fuel_low    = (rf == REGION_LOW);
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    lamp_word_t want;
    lamp_word_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[4:0];
      if (lamps_due.size() == 0) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS) begin
          $display("%0t: unexpected result tdata=%02h", $realtime, m_axis_tdata);
        end
      end else begin
        want = lamps_due.pop_front();
        if (got.led_fuel !== want.led_fuel || got.led_battery !== want.led_battery ||
            got.led_ok !== want.led_ok || got.battery_low !== want.battery_low ||
            got.fuel_low !== want.fuel_low || m_axis_tdata[7:5] !== 3'b000) begin
          fault_count++;
          if (fault_count <= MAX_REPORTS) begin
            $display("%0t: result mismatch led_fuel %b/%b led_battery %b/%b led_ok %b/%b",
                     $realtime, want.led_fuel, got.led_fuel, want.led_battery,
                     got.led_battery, want.led_ok, got.led_ok);
            $display("    battery_low %b/%b fuel_low %b/%b pad 000/%b (expected/actual)",
                     want.battery_low, got.battery_low, want.fuel_low, got.fuel_low,
                     m_axis_tdata[7:5]);
          end
        end
      end
    end
  end

  // Result sink with random stalls and the long hold-off
  initial begin : result_sink
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = recv_idle_on ? $urandom_range(11, 0) : 0;
      if (stall > 0 || hold_left != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
        while (hold_left != 0) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  // ---------------------------------------------------------------------------
  // Shared driving tasks
  // ---------------------------------------------------------------------------

  // Offer one request, wait for accept, record the expected result
  task automatic send_level(logic [7:0] batt, logic [7:0] fuel, logic [31:0] tick);
    int gap;
    gap = send_idle_on ? $urandom_range(11, 0) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {tick, fuel, batt};
    do @(posedge clk); while (!s_axis_tready);
    lamps_due.push_back(update_lamps(batt, fuel, tick));
  endtask

  // Stop sending and let the pipeline empty
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (lamps_due.size() != 0) @(posedge clk);
    repeat (PIPE_CYCLES + 1) @(posedge clk);
  endtask

  task automatic set_thresholds(logic [7:0] hi, logic [7:0] lo);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_HIGH_THRESHOLD;
    cfg_data  <= hi;
    do @(posedge clk); while (!cfg_ready);
    thr_high = hi;
    cfg_index <= CFG_LOW_THRESHOLD;
    cfg_data  <= lo;
    do @(posedge clk); while (!cfg_ready);
    thr_low = lo;
    cfg_valid <= 1'b0;
  endtask

  // Random level inside a region under the current thresholds, sometimes on an edge
  function automatic logic [7:0] level_in(region_t r);
    logic [7:0] v;
    int         lo_top;
    if ($urandom_range(7, 0) == 0) begin
      case ($urandom_range(3, 0))
        0:       v = thr_low;
        1:       v = thr_low + 8'd1;
        2:       v = thr_high;
        default: v = thr_high + 8'd1;
      endcase
      return v;
    end
    case (r)
      REGION_HIGH: begin
        v = (thr_high == 8'hFF) ? 8'($urandom()) : 8'($urandom_range(255, int'(thr_high) + 1));
      end
      REGION_MED: begin
        v = (thr_low < thr_high) ? 8'($urandom_range(int'(thr_high), int'(thr_low) + 1))
                                 : 8'($urandom());
      end
      default: begin
        lo_top = (thr_low < thr_high) ? int'(thr_low) : int'(thr_high);
        v = 8'($urandom_range(lo_top, 0));
      end
    endcase
    return v;
  endfunction

  function automatic logic [31:0] tick_step();
    logic [31:0] s;
    case ($urandom_range(7, 0))
      0:       s = 32'd0;
      1:       s = 32'd1;
      2:       s = 32'd50;
      3:       s = FAST_TICKS;
      4:       s = SLOW_TICKS;
      5:       s = $urandom_range(300, 0);
      6:       s = FAST_TICKS * $urandom_range(5, 1);
      default: s = $urandom();
    endcase
    return s;
  endfunction

  // Runs of advancing ticks with mostly steady regions, plus some noise requests
  task automatic run_blink_sequences(int n);
    int          sent;
    int          len;
    logic [31:0] t;
    region_t     rb;
    region_t     rf;
    sent = 0;
    while (sent < n) begin
      send_idle_on = ($urandom_range(3, 0) != 0);
      recv_idle_on = ($urandom_range(3, 0) != 0);
      if ($urandom_range(9, 0) == 0) begin
        send_level(8'($urandom()), 8'($urandom()), $urandom());
        sent++;
      end else begin
        len = $urandom_range(40, 5);
        t   = ($urandom_range(3, 0) == 0) ? 32'hFFFF_FFFF - $urandom_range(2000, 0) : $urandom();
        rb  = region_t'($urandom_range(2, 0));
        rf  = region_t'($urandom_range(2, 0));
        repeat (len) begin
          if ($urandom_range(7, 0) == 0) rb = region_t'($urandom_range(2, 0));
          if ($urandom_range(7, 0) == 0) rf = region_t'($urandom_range(2, 0));
          send_level(level_in(rb), level_in(rf), t);
          t += tick_step();
          sent++;
        end
      end
    end
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset thresholds: start in low, entries, both high, one high, tick wrap
  task automatic test_directed_defaults();
    send_level(8'd0,   8'd10,  32'd0);
    send_level(8'd5,   8'd3,   32'd100);
    send_level(8'd5,   8'd3,   32'd150);
    send_level(8'd255, 8'd255, 32'd160);
    send_level(8'd10,  8'd11,  32'd200);
    send_level(8'd11,  8'd50,  32'd400);
    send_level(8'd51,  8'd50,  32'd500);
    send_level(8'd50,  8'd51,  32'd600);
    send_level(8'd51,  8'd51,  32'd700);
    send_level(8'd20,  8'd0,   32'hFFFF_FFFF);
    send_level(8'd20,  8'd0,   32'h0000_0063);
    send_level(8'd128, 8'd0,   32'h8000_0000);
    send_level(8'd0,   8'd255, 32'h0000_00C7);
    send_level(8'd255, 8'd0,   32'h7FFF_FFFF);
  endtask

  // Low threshold above high threshold: no medium region
  task automatic test_crossed_thresholds();
    set_thresholds(8'd10, 8'd200);
    send_level(8'd0,   8'd10,  32'd1000);
    send_level(8'd11,  8'd200, 32'd1100);
    send_level(8'd201, 8'd255, 32'd1200);
    send_level(8'd10,  8'd11,  32'd1300);
    send_level(8'd9,   8'd5,   32'd1400);
    send_level(8'd255, 8'd0,   32'd1500);
  endtask

  task automatic test_threshold_extremes();
    set_thresholds(8'd255, 8'd0);
    run_blink_sequences(100);
    set_thresholds(8'd0, 8'd255);
    run_blink_sequences(80);
    set_thresholds(8'd0, 8'd0);
    run_blink_sequences(80);
    set_thresholds(8'd255, 8'd255);
    run_blink_sequences(80);
  endtask

  task automatic test_random_thresholds();
    logic [7:0] a;
    logic [7:0] b;
    repeat (5) begin
      a = 8'($urandom());
      b = 8'($urandom());
      // mostly ordered so that all three regions exist
      if ($urandom_range(3, 0) != 0 && a < b) begin
        set_thresholds(b, a);
      end else begin
        set_thresholds(a, b);
      end
      run_blink_sequences(90);
    end
  endtask

  task automatic test_default_sequences();
    set_thresholds(HIGH_THRESHOLD_RST, LOW_THRESHOLD_RST);
    run_blink_sequences(420);
  endtask

  // Receiver holds off long enough for the pipeline to fill and stall the input
  task automatic test_output_backpressure();
    logic [31:0] t;
    wait_idle();
    t = $urandom();
    send_idle_on = 1'b0;
    hold_left <= 120;
    repeat (40) begin
      send_level(level_in(REGION_MED), level_in(REGION_LOW), t);
      t += FAST_TICKS;
    end
    send_idle_on = 1'b1;
  endtask

  // Sender stops until every result is back, then resumes the same run
  task automatic test_sender_pause();
    logic [31:0] t;
    t = $urandom();
    repeat (20) begin
      send_level(level_in(REGION_LOW), level_in(REGION_MED), t);
      t += tick_step();
    end
    wait_idle();
    repeat (20) begin
      send_level(level_in(REGION_LOW), level_in(REGION_MED), t);
      t += tick_step();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    thr_high            = HIGH_THRESHOLD_RST;
    thr_low             = LOW_THRESHOLD_RST;
    batt_chan.ref_tick  = '0;
    batt_chan.expect_med = 1'b1;
    batt_chan.toggle    = 1'b0;
    batt_chan.led       = 1'b0;
    fuel_chan           = batt_chan;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_defaults();
    test_crossed_thresholds();
    test_threshold_extremes();
    test_random_thresholds();
    test_default_sequences();
    test_output_backpressure();
    test_sender_pause();

    wait_idle();
    repeat (10) @(posedge clk);
    if (fault_count == 0) begin
      $display("PASS level_warning_led_blinker_top");
    end else begin
      $display("FAIL level_warning_led_blinker_top");
    end
    $finish;
  end

endmodule

### sim.f
src/lvb_pkg.sv
src/lvb_mod.sv
src/lvb_chan.sv
src/level_warning_led_blinker_top.sv
tb/sv/tb_top.sv
